// ===== hw/rtl/bse_pkg.sv =====
// Shared types and constants for the byte histogram entropy block.
`default_nettype none
package bse_pkg;

    localparam int NUM_BINS  = 256;
    localparam int BIN_W     = 8;
    localparam int ENT_W     = 20;
    localparam int TOT_W     = 22;
    localparam int LOG_FRAC  = 28;
    localparam int MANT_FRAC = 30;
    localparam int EXP_W     = 5;
    localparam int LOG_W     = EXP_W + LOG_FRAC;
    localparam int SUM_W     = 64;

    // Scan request from the sequencer to the histogram store.
    typedef struct packed {
        logic             rd;
        logic             clr;
        logic [BIN_W-1:0] bin;
    } bse_scan_t;

endpackage
`default_nettype wire

// ===== hw/rtl/bse_in_if.sv =====
// Byte request channel: one buffer byte with its valid and last marks.
`default_nettype none
interface bse_in_if;
    logic                        valid;
    logic                        ready;
    logic [bse_pkg::BIN_W-1:0]   data_byte;
    logic                        byte_valid;
    logic                        last_byte;

    modport source (output valid, data_byte, byte_valid, last_byte, input ready);
    modport sink (input valid, data_byte, byte_valid, last_byte, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/bse_out_if.sv =====
// Result request channel: entropy, byte count and overflow flag.
`default_nettype none
interface bse_out_if;
    logic                        valid;
    logic                        ready;
    logic [bse_pkg::ENT_W-1:0]   entropy_bits;
    logic [bse_pkg::TOT_W-1:0]   total_bytes;
    logic                        count_overflow;

    modport source (output valid, entropy_bits, total_bytes, count_overflow, input ready);
    modport sink (input valid, entropy_bits, total_bytes, count_overflow, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/bse_hist.sv =====
// Histogram store: 256 counters in a memory with per-bin valid bits.
`default_nettype none
module bse_hist #(
    parameter int CNT_W = 22
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      acc_en,
    input  wire logic                      acc_inc,
    input  wire logic [bse_pkg::BIN_W-1:0] acc_byte,
    input  wire bse_pkg::bse_scan_t        scan,
    output logic [CNT_W-1:0]               scan_data
);

    logic [CNT_W-1:0]            mem [bse_pkg::NUM_BINS];
    logic [bse_pkg::NUM_BINS-1:0] vld_reg;
    logic [CNT_W-1:0]            rd_data_reg;
    logic                        vld_q_reg;
    logic                        p_act_reg, p_act_next;
    logic [bse_pkg::BIN_W-1:0]   p_addr_reg, p_addr_next;
    logic                        fwd_reg, fwd_next;
    logic [CNT_W-1:0]            fwd_data_reg;
    logic [bse_pkg::BIN_W-1:0]   rd_addr;
    logic [CNT_W-1:0]            cur;
    logic [CNT_W-1:0]            wr_data;

    // A scan read takes the port, otherwise the incoming byte is looked up.
    assign rd_addr = scan.rd ? scan.bin : acc_byte;

    // Current count of the bin in the second stage, bypassing a write just made.
    always_comb
    begin
        if (fwd_reg)
        begin
            cur = fwd_data_reg;
        end
        else if (vld_q_reg)
        begin
            cur = rd_data_reg;
        end
        else
        begin
            cur = '0;
        end
    end

    assign wr_data   = cur + CNT_W'(1);
    assign scan_data = vld_q_reg ? rd_data_reg : '0;

    assign p_act_next  = acc_en && acc_inc;
    assign p_addr_next = acc_byte;
    assign fwd_next    = acc_en && acc_inc && p_act_reg && (p_addr_reg == acc_byte);

    // Counter memory with registered read.
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
        if (p_act_reg)
        begin
            mem[p_addr_reg] <= wr_data;
        end
        fwd_data_reg <= wr_data;
        p_addr_reg   <= p_addr_next;
    end

    // Valid bits and pipeline control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            vld_q_reg <= 1'b0;
            p_act_reg <= 1'b0;
            fwd_reg   <= 1'b0;
        end
        else
        begin
            vld_q_reg <= vld_reg[rd_addr];
            if (p_act_reg)
            begin
                vld_reg[p_addr_reg] <= 1'b1;
            end
            if (scan.clr)
            begin
                vld_reg[scan.bin] <= 1'b0;
            end
            p_act_reg <= p_act_next;
            fwd_reg   <= fwd_next;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/bse_log2.sv =====
// Iterative Q28 log2 unit: bit-serial normalization, then one squaring a cycle.
`default_nettype none
module bse_log2 #(
    parameter int VAL_W = 22
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [VAL_W-1:0]          value,
    output logic                           done,
    output logic [bse_pkg::LOG_W-1:0]      result
);

    localparam int M_W  = bse_pkg::MANT_FRAC + 1;
    localparam int SQ_W = 2 * M_W;
    localparam int IT_W = $clog2(bse_pkg::LOG_FRAC);

    typedef enum logic [2:0] {
        L_IDLE = 3'b001,
        L_NORM = 3'b010,
        L_SQR  = 3'b100
    } lg_state_t;

    lg_state_t                        st_reg, st_next;
    logic [M_W-1:0]                   m_reg, m_next;
    logic [bse_pkg::EXP_W-1:0]        e_reg, e_next;
    logic [bse_pkg::LOG_FRAC-1:0]     frac_reg, frac_next;
    logic [IT_W-1:0]                  it_reg, it_next;
    logic                             done_reg, done_next;
    logic [SQ_W-1:0]                  sq;
    logic [M_W:0]                     t;

    assign sq = m_reg * m_reg;
    assign t  = sq[SQ_W-1:bse_pkg::MANT_FRAC];

    // Sequencer for normalization and squaring rounds.
    always_comb
    begin
        st_next   = st_reg;
        m_next    = m_reg;
        e_next    = e_reg;
        frac_next = frac_reg;
        it_next   = it_reg;
        done_next = 1'b0;
        case (st_reg)
            L_IDLE:
            begin
                if (start)
                begin
                    m_next    = M_W'(value);
                    e_next    = bse_pkg::EXP_W'(bse_pkg::MANT_FRAC);
                    frac_next = '0;
                    st_next   = L_NORM;
                end
            end
            L_NORM:
            begin
                // Shift until the top bit lands on the integer position.
                if (m_reg[M_W-1])
                begin
                    it_next = '0;
                    st_next = L_SQR;
                end
                else
                begin
                    m_next = {m_reg[M_W-2:0], 1'b0};
                    e_next = e_reg - bse_pkg::EXP_W'(1);
                end
            end
            L_SQR:
            begin
                // Square; a result of two or more gives a one bit.
                if (t[M_W])
                begin
                    m_next    = t[M_W:1];
                    frac_next = {frac_reg[bse_pkg::LOG_FRAC-2:0], 1'b1};
                end
                else
                begin
                    m_next    = t[M_W-1:0];
                    frac_next = {frac_reg[bse_pkg::LOG_FRAC-2:0], 1'b0};
                end
                it_next = it_reg + IT_W'(1);
                if (it_reg == IT_W'(bse_pkg::LOG_FRAC - 1))
                begin
                    done_next = 1'b1;
                    st_next   = L_IDLE;
                end
            end
            default:
            begin
                st_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= L_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg    <= m_next;
        e_reg    <= e_next;
        frac_reg <= frac_next;
        it_reg   <= it_next;
    end

    assign done   = done_reg;
    assign result = {e_reg, frac_reg};

endmodule
`default_nettype wire

// ===== hw/rtl/bse_div.sv =====
// Restoring divider: one quotient bit per cycle.
`default_nettype none
module bse_div #(
    parameter int DIV_W = 22
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [bse_pkg::SUM_W-1:0] dividend,
    input  wire logic [DIV_W-1:0]          divisor,
    output logic                           done,
    output logic [bse_pkg::SUM_W-1:0]      quotient
);

    localparam int CT_W = $clog2(bse_pkg::SUM_W);

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [CT_W-1:0]              ct_reg, ct_next;
    logic [DIV_W-1:0]             rem_reg, rem_next;
    logic [DIV_W-1:0]             dv_reg, dv_next;
    logic [bse_pkg::SUM_W-1:0]    quo_reg, quo_next;
    logic [DIV_W:0]               r2;
    logic                         fits;

    assign r2   = {rem_reg, quo_reg[bse_pkg::SUM_W-1]};
    assign fits = (r2 >= {1'b0, dv_reg});

    // One compare and subtract per step.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        ct_next   = ct_reg;
        rem_next  = rem_reg;
        dv_next   = dv_reg;
        quo_next  = quo_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                ct_next   = '0;
                rem_next  = '0;
                dv_next   = divisor;
                quo_next  = dividend;
            end
        end
        else
        begin
            rem_next = fits ? DIV_W'(r2 - {1'b0, dv_reg}) : r2[DIV_W-1:0];
            quo_next = {quo_reg[bse_pkg::SUM_W-2:0], fits};
            ct_next  = ct_reg + CT_W'(1);
            if (ct_reg == CT_W'(bse_pkg::SUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ct_reg  <= ct_next;
        rem_reg <= rem_next;
        dv_reg  <= dv_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/byte_shannon_entropy.sv =====
// Byte histogram Shannon entropy: top level and pass sequencer.
// Throughput: one byte per cycle while a buffer is taken; not ready during the pass.
// After the last byte: a drain state, then a read per bin; an empty bin is skipped, a used
//   bin gets a log2 and a multiply-accumulate; then the log2 of the total and the divide.
// An empty buffer skips all of it. The shared log2 unit sets the per-bin cost.
// Reset clears all bins through their valid bits, the count and the flag at once.
`default_nettype none
module byte_shannon_entropy #(
    parameter int MAX_BYTES     = 2097152,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    bse_in_if.sink    data_ch,
    bse_out_if.source result_ch
);

    localparam int CNT_W = $clog2(MAX_BYTES + 1);
    localparam int LG_W  = bse_pkg::LOG_W;
    localparam int LO_W  = 17;
    localparam int HI_W  = LG_W - LO_W;
    localparam int PR_W  = CNT_W + LO_W;
    localparam int SH    = bse_pkg::LOG_FRAC - FRACTION_BITS;
    localparam logic [LG_W:0] RND = (LG_W + 1)'(1) << (SH - 1);
    localparam logic [LG_W:0] TOP = (LG_W + 1)'(8) << FRACTION_BITS;

    typedef enum logic [11:0] {
        S_ACC    = 12'd1,
        S_DRAIN  = 12'd2,
        S_RD     = 12'd4,
        S_LD     = 12'd8,
        S_LOG    = 12'd16,
        S_MUL0   = 12'd32,
        S_MUL1   = 12'd64,
        S_NSTART = 12'd128,
        S_NLOG   = 12'd256,
        S_DIV    = 12'd512,
        S_FIN    = 12'd1024,
        S_OUT    = 12'd2048
    } bse_state_t;

    bse_state_t                    st_reg, st_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic                          ovf_reg, ovf_next;
    logic [bse_pkg::BIN_W-1:0]     bin_reg, bin_next;
    logic [CNT_W-1:0]              c_reg, c_next;
    logic [LG_W-1:0]               lg_reg, lg_next;
    logic [LG_W-1:0]               ln_reg, ln_next;
    logic [LG_W-1:0]               h_reg, h_next;
    logic [bse_pkg::SUM_W-1:0]     sum_reg, sum_next;
    logic                          out_vld_reg, out_vld_next;
    logic [bse_pkg::ENT_W-1:0]     ent_reg, ent_next;
    logic [bse_pkg::TOT_W-1:0]     tot_reg, tot_next;
    logic                          oflag_reg, oflag_next;
    logic [bse_pkg::ENT_W-1:0]     res_ent_reg, res_ent_next;
    logic [bse_pkg::TOT_W-1:0]     res_tot_reg, res_tot_next;
    logic                          res_ovf_reg, res_ovf_next;

    logic                          accept;
    logic                          sat;
    logic                          acc_inc;
    bse_pkg::bse_scan_t            scan;
    logic [CNT_W-1:0]              scan_data;
    logic                          log_start;
    logic [CNT_W-1:0]              log_val;
    logic                          log_done;
    logic [LG_W-1:0]               log_res;
    logic                          div_start;
    logic                          div_done;
    logic [bse_pkg::SUM_W-1:0]     div_q;
    logic [LO_W-1:0]               mul_b;
    logic [PR_W-1:0]               prod;
    logic [LG_W:0]                 hr;
    logic                          slot_free;

    assign accept  = data_ch.valid && data_ch.ready;
    assign sat     = (cnt_reg == CNT_W'(MAX_BYTES));
    assign acc_inc = data_ch.byte_valid && !sat;

    assign data_ch.ready = (st_reg == S_ACC);

    // Histogram counters.
    bse_hist #(
        .CNT_W (CNT_W)
    ) u_hist (
        .clk       (clk),
        .rst_n     (rst_n),
        .acc_en    (accept),
        .acc_inc   (acc_inc),
        .acc_byte  (data_ch.data_byte),
        .scan      (scan),
        .scan_data (scan_data)
    );

    // Shared log2 unit.
    bse_log2 #(
        .VAL_W (CNT_W)
    ) u_log2 (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (log_start),
        .value  (log_val),
        .done   (log_done),
        .result (log_res)
    );

    // Divider for the weighted sum over the total.
    bse_div #(
        .DIV_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // One multiplier, used on the low and then the high part of the log.
    assign mul_b = (st_reg == S_MUL0) ? lg_reg[LO_W-1:0] : LO_W'(lg_reg[LG_W-1:LO_W]);
    assign prod  = PR_W'(c_reg) * PR_W'(mul_b);

    // Rounding of the entropy to the output fraction width.
    assign hr = ({1'b0, h_reg} + RND) >> SH;

    assign slot_free = !out_vld_reg || result_ch.ready;

    // Pass sequencer.
    always_comb
    begin
        st_next      = st_reg;
        cnt_next     = cnt_reg;
        ovf_next     = ovf_reg;
        bin_next     = bin_reg;
        c_next       = c_reg;
        lg_next      = lg_reg;
        ln_next      = ln_reg;
        h_next       = h_reg;
        sum_next     = sum_reg;
        res_ent_next = res_ent_reg;
        res_tot_next = res_tot_reg;
        res_ovf_next = res_ovf_reg;
        scan         = '0;
        log_start    = 1'b0;
        log_val      = scan_data;
        div_start    = 1'b0;
        case (st_reg)
            S_ACC:
            begin
                if (accept)
                begin
                    if (data_ch.byte_valid)
                    begin
                        if (sat)
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            cnt_next = cnt_reg + CNT_W'(1);
                        end
                    end
                    if (data_ch.last_byte)
                    begin
                        bin_next = '0;
                        sum_next = '0;
                        st_next  = S_DRAIN;
                    end
                end
            end
            S_DRAIN:
            begin
                // The last byte's counter write completes here.
                st_next = (cnt_reg == '0) ? S_FIN : S_RD;
            end
            S_RD:
            begin
                scan.rd  = 1'b1;
                scan.bin = bin_reg;
                st_next  = S_LD;
            end
            S_LD:
            begin
                if (scan_data == '0)
                begin
                    bin_next = bin_reg + bse_pkg::BIN_W'(1);
                    st_next  = (bin_reg == '1) ? S_NSTART : S_RD;
                end
                else
                begin
                    c_next    = scan_data;
                    scan.clr  = 1'b1;
                    scan.bin  = bin_reg;
                    log_start = 1'b1;
                    st_next   = S_LOG;
                end
            end
            S_LOG:
            begin
                if (log_done)
                begin
                    lg_next = log_res;
                    st_next = S_MUL0;
                end
            end
            S_MUL0:
            begin
                sum_next = sum_reg + bse_pkg::SUM_W'(prod);
                st_next  = S_MUL1;
            end
            S_MUL1:
            begin
                sum_next = sum_reg + (bse_pkg::SUM_W'(prod) << LO_W);
                bin_next = bin_reg + bse_pkg::BIN_W'(1);
                st_next  = (bin_reg == '1) ? S_NSTART : S_RD;
            end
            S_NSTART:
            begin
                log_start = 1'b1;
                log_val   = cnt_reg;
                st_next   = S_NLOG;
            end
            S_NLOG:
            begin
                if (log_done)
                begin
                    ln_next   = log_res;
                    div_start = 1'b1;
                    st_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (bse_pkg::SUM_W'(ln_reg) > div_q)
                    begin
                        h_next = ln_reg - LG_W'(div_q);
                    end
                    else
                    begin
                        h_next = '0;
                    end
                    st_next = S_FIN;
                end
            end
            S_FIN:
            begin
                // Round, clamp, and capture before the buffer state clears.
                if (cnt_reg == '0)
                begin
                    res_ent_next = '0;
                end
                else if (hr > TOP)
                begin
                    res_ent_next = (bse_pkg::ENT_W)'(TOP);
                end
                else
                begin
                    res_ent_next = (bse_pkg::ENT_W)'(hr);
                end
                res_tot_next = (bse_pkg::TOT_W)'(cnt_reg);
                res_ovf_next = ovf_reg;
                cnt_next     = '0;
                ovf_next     = 1'b0;
                st_next      = S_OUT;
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    st_next = S_ACC;
                end
            end
            default:
            begin
                st_next = S_ACC;
            end
        endcase
    end

    // Output register.
    always_comb
    begin
        out_vld_next = out_vld_reg;
        ent_next     = ent_reg;
        tot_next     = tot_reg;
        oflag_next   = oflag_reg;
        if (result_ch.ready)
        begin
            out_vld_next = 1'b0;
        end
        if ((st_reg == S_OUT) && slot_free)
        begin
            out_vld_next = 1'b1;
            ent_next     = res_ent_reg;
            tot_next     = res_tot_reg;
            oflag_next   = res_ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= S_ACC;
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            st_reg      <= st_next;
            cnt_reg     <= cnt_next;
            ovf_reg     <= ovf_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg     <= bin_next;
        c_reg       <= c_next;
        lg_reg      <= lg_next;
        ln_reg      <= ln_next;
        h_reg       <= h_next;
        sum_reg     <= sum_next;
        ent_reg     <= ent_next;
        tot_reg     <= tot_next;
        oflag_reg   <= oflag_next;
        res_ent_reg <= res_ent_next;
        res_tot_reg <= res_tot_next;
        res_ovf_reg <= res_ovf_next;
    end

    assign result_ch.valid          = out_vld_reg;
    assign result_ch.entropy_bits   = ent_reg;
    assign result_ch.total_bytes    = tot_reg;
    assign result_ch.count_overflow = oflag_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/bse_chk.sv =====
// Port-level checker for the entropy block and its bind.
`default_nettype none
module bse_chk #(
    parameter int FRACTION_BITS = 16
) (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      in_valid,
    input wire logic                      in_ready,
    input wire logic                      in_last,
    input wire logic                      out_valid,
    input wire logic                      out_ready,
    input wire logic [bse_pkg::ENT_W-1:0] out_ent,
    input wire logic [bse_pkg::TOT_W-1:0] out_tot,
    input wire logic                      out_ovf
);

    // A held result keeps its fields.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_ent) && $stable(out_tot)
        && $stable(out_ovf))
        else $error("result changed while stalled");

    // After the last byte the block stops taking bytes for its pass.
    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> !in_ready)
        else $error("byte taken during entropy pass");

    // Entropy never exceeds eight bits per byte.
    a_ent_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({12'd0, out_ent} <= (32'd8 << FRACTION_BITS)))
        else $error("entropy above eight bits");

    // An empty buffer has zero entropy.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_tot == '0) && !out_ovf |-> (out_ent == '0))
        else $error("nonzero entropy for empty buffer");

endmodule

bind byte_shannon_entropy bse_chk #(
    .FRACTION_BITS (FRACTION_BITS)
) u_bse_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (data_ch.valid),
    .in_ready  (data_ch.ready),
    .in_last   (data_ch.last_byte),
    .out_valid (result_ch.valid),
    .out_ready (result_ch.ready),
    .out_ent   (result_ch.entropy_bits),
    .out_tot   (result_ch.total_bytes),
    .out_ovf   (result_ch.count_overflow)
);
`default_nettype wire

// ===== tb/bse_tb_if.sv =====
// Testbench request and result types for the entropy block.
package bse_tb_pkg;

    // One byte request as the sender offers it.
    typedef struct packed {
        logic [bse_pkg::BIN_W-1:0] data_byte;
        logic                      byte_valid;
        logic                      last_byte;
    } byte_req_t;

    // One entropy result as it should leave the block.
    typedef struct packed {
        logic [bse_pkg::ENT_W-1:0] entropy_bits;
        logic [bse_pkg::TOT_W-1:0] total_bytes;
        logic                      count_overflow;
    } entropy_res_t;
endpackage

// ===== tb/tb.sv =====
// Self-checking testbench for the byte histogram entropy block.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_B   = 2097152;
    localparam int FRAC    = 16;
    localparam int N_ITEMS = 1850;
    localparam int N_DIR   = 12;
    localparam int N_HOLD  = 60;
    localparam int N_RAND  = N_ITEMS - N_DIR - bse_pkg::NUM_BINS - N_HOLD;

    logic clk;
    logic rst_n;
    bse_in_if  data_ch ();
    bse_out_if result_ch ();

    byte_shannon_entropy #(.MAX_BYTES(MAX_B), .FRACTION_BITS(FRAC)) dut (
        .clk(clk), .rst_n(rst_n), .data_ch(data_ch), .result_ch(result_ch)
    );

    // Predictor state.
    logic [31:0] bin_count [bse_pkg::NUM_BINS];
    logic [31:0] pred_total;
    logic        pred_ovf;
    bse_tb_pkg::entropy_res_t entropy_q [$];
    int errors;
    bit hold_long;
    bit stim_done;

    initial begin
        clk = 1'b0;
        forever
        begin
            #1 clk = 1'b1;
            #1 clk = 1'b0;
        end
    end

    // Truncated Q28 log2 of v >= 1 by repeated squaring.
    function automatic logic [63:0] log2_q28(input logic [31:0] v);
        logic [63:0] m;
        logic [63:0] fr;
        int e;
        e = 0;
        fr = 0;
        for (int k = 31; k >= 0; k--)
        begin
            if (v[k] && e == 0 && k > 0 && (v >> k) == 1) e = k;
        end
        m = 64'(v) << (bse_pkg::MANT_FRAC - e);
        for (int i = 0; i < bse_pkg::LOG_FRAC; i++)
        begin
            m = (m * m) >> bse_pkg::MANT_FRAC;
            fr = fr << 1;
            if (m >= (64'd1 << (bse_pkg::MANT_FRAC + 1)))
            begin
                fr = fr | 64'd1;
                m = m >> 1;
            end
        end
        return (64'(e) << bse_pkg::LOG_FRAC) | fr;
    endfunction

    function automatic logic [bse_pkg::ENT_W-1:0] entropy_of_bins();
        logic [63:0] s;
        logic [63:0] ln;
        logic [63:0] q;
        logic [63:0] h;
        s = 0;
        if (pred_total == 0) return '0;
        for (int i = 0; i < bse_pkg::NUM_BINS; i++)
        begin
            if (bin_count[i] != 0) s += 64'(bin_count[i]) * log2_q28(bin_count[i]);
        end
        ln = log2_q28(pred_total);
        q = s / pred_total;
        h = (ln > q) ? ln - q : 64'd0;
        h = (h + (64'd1 << (bse_pkg::LOG_FRAC - FRAC - 1))) >> (bse_pkg::LOG_FRAC - FRAC);
        if (h > (64'd8 << FRAC)) h = 64'd8 << FRAC;
        return h[bse_pkg::ENT_W-1:0];
    endfunction

    // Update the histogram for one accepted request; queue a result on last.
    task automatic predict_byte(input bse_tb_pkg::byte_req_t r);
        bse_tb_pkg::entropy_res_t res;
        if (r.byte_valid)
        begin
            if (pred_total >= MAX_B) pred_ovf = 1'b1;
            else
            begin
                bin_count[r.data_byte]++;
                pred_total++;
            end
        end
        if (r.last_byte)
        begin
            res.entropy_bits = entropy_of_bins();
            res.total_bytes = pred_total[bse_pkg::TOT_W-1:0];
            res.count_overflow = pred_ovf;
            entropy_q.push_back(res);
            foreach (bin_count[i]) bin_count[i] = 0;
            pred_total = 0;
            pred_ovf = 1'b0;
        end
    endtask

    function automatic int gap_len();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) n = 0;
        return n;
    endfunction

    // Sometimes drop valid for a random number of cycles.
    task automatic pause_maybe();
        int n;
        n = ($urandom_range(0, 2) == 0) ? gap_len() : 0;
        if (n > 0)
        begin
            data_ch.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Offer one request and wait until it is accepted.
    task automatic send_byte(input bse_tb_pkg::byte_req_t r);
        logic ok;
        data_ch.valid <= 1'b1;
        data_ch.data_byte <= r.data_byte;
        data_ch.byte_valid <= r.byte_valid;
        data_ch.last_byte <= r.last_byte;
        ok = 1'b0;
        while (!ok)
        begin
            @(negedge clk);
            ok = data_ch.ready;
            @(posedge clk);
        end
        predict_byte(r);
    endtask

    task automatic send_idle(input bse_tb_pkg::byte_req_t r);
        send_byte(r);
        pause_maybe();
    endtask

    // Directed table; expected entropy typed in where it is obvious, else -1.
    bse_tb_pkg::byte_req_t dir_req [N_DIR];
    int                    dir_ent [N_DIR];

    initial begin
        bse_tb_pkg::byte_req_t r;
        int cnt;
        int len;
        logic [7:0] base;
        dir_req[0]  = '{8'h00, 1'b0, 1'b1}; dir_ent[0]  = 0;   // empty buffer
        dir_req[1]  = '{8'hFF, 1'b1, 1'b1}; dir_ent[1]  = 0;   // one byte
        dir_req[2]  = '{8'h00, 1'b1, 1'b0}; dir_ent[2]  = -1;
        dir_req[3]  = '{8'hFF, 1'b1, 1'b1}; dir_ent[3]  = 65536; // two values: 1 bit
        dir_req[4]  = '{8'hAA, 1'b1, 1'b0}; dir_ent[4]  = -1;
        dir_req[5]  = '{8'h55, 1'b0, 1'b0}; dir_ent[5]  = -1;  // ignored byte
        dir_req[6]  = '{8'hAA, 1'b1, 1'b0}; dir_ent[6]  = -1;
        dir_req[7]  = '{8'h12, 1'b0, 1'b1}; dir_ent[7]  = 0;   // single value, invalid last
        dir_req[8]  = '{8'h01, 1'b1, 1'b0}; dir_ent[8]  = -1;
        dir_req[9]  = '{8'h02, 1'b1, 1'b0}; dir_ent[9]  = -1;
        dir_req[10] = '{8'h03, 1'b1, 1'b0}; dir_ent[10] = -1;
        dir_req[11] = '{8'h04, 1'b1, 1'b1}; dir_ent[11] = 131072; // four values: 2 bits

        foreach (bin_count[i]) bin_count[i] = 0;
        pred_total = 0;
        pred_ovf = 1'b0;
        errors = 0;
        hold_long = 1'b0;
        stim_done = 1'b0;
        data_ch.valid = 1'b0;
        data_ch.data_byte = '0;
        data_ch.byte_valid = 1'b0;
        data_ch.last_byte = 1'b0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIR; i++)
        begin
            send_byte(dir_req[i]);
            if (dir_ent[i] >= 0 && dir_req[i].last_byte &&
                entropy_q[$].entropy_bits != dir_ent[i])
            begin
                $error("table entropy_bits row %0d: expected %0d, got %0d",
                       i, dir_ent[i], entropy_q[$].entropy_bits);
                errors++;
            end
            pause_maybe();
        end

        // Full 256-value buffer: every byte value once gives 8 bits.
        for (int v = 0; v < bse_pkg::NUM_BINS; v++)
            send_byte('{8'(v), 1'b1, v == bse_pkg::NUM_BINS - 1});
        data_ch.valid <= 1'b0;
        if (entropy_q[$].entropy_bits != (8 << FRAC))
        begin
            $error("uniform entropy_bits: expected %0d, got %0d",
                   8 << FRAC, entropy_q[$].entropy_bits);
            errors++;
        end

        // Sender pause until every result is out.
        while (entropy_q.size() != 0) @(posedge clk);

        // Receiver holds off while the sender keeps offering.
        hold_long <= 1'b1;
        for (int i = 0; i < N_HOLD; i++)
        begin
            r.data_byte = 8'($urandom);
            r.byte_valid = 1'b1;
            r.last_byte = (i % 6 == 5);
            send_byte(r);
        end
        hold_long <= 1'b0;

        // Random buffers: mostly short, skewed alphabets, some noise.
        cnt = 0;
        while (cnt < N_RAND)
        begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 400)
                                                : $urandom_range(0, 24);
            base = 8'($urandom);
            for (int i = 0; i <= len; i++)
            begin
                r.data_byte = ($urandom_range(0, 1)) ? 8'($urandom)
                              : base + 8'($urandom_range(0, 3));
                r.byte_valid = ($urandom_range(0, 7) != 0);
                r.last_byte = (i == len);
                send_idle(r);
                cnt++;
            end
        end
        data_ch.valid <= 1'b0;
        stim_done <= 1'b1;
    end

    // Receiver: random stalls, plus one long hold-off counted here.
    initial begin
        int n;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_long)
            begin
                result_ch.ready <= 1'b0;
                n = 0;
                while (n < 3000)
                begin
                    @(posedge clk);
                    n++;
                end
                result_ch.ready <= 1'b1;
                while (hold_long) @(posedge clk);
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                result_ch.ready <= 1'b0;
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(1, 3);
                repeat (n - 1) @(posedge clk);
            end
            else result_ch.ready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        bse_tb_pkg::entropy_res_t e;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (entropy_q.size() == 0)
            begin
                $error("unexpected result: entropy_bits %0d", result_ch.entropy_bits);
                errors++;
            end
            else
            begin
                e = entropy_q.pop_front();
                if (result_ch.entropy_bits !== e.entropy_bits)
                begin
                    $error("entropy_bits: expected %0d, got %0d",
                           e.entropy_bits, result_ch.entropy_bits);
                    errors++;
                end
                if (result_ch.total_bytes !== e.total_bytes)
                begin
                    $error("total_bytes: expected %0d, got %0d",
                           e.total_bytes, result_ch.total_bytes);
                    errors++;
                end
                if (result_ch.count_overflow !== e.count_overflow)
                begin
                    $error("count_overflow: expected %0d, got %0d",
                           e.count_overflow, result_ch.count_overflow);
                    errors++;
                end
            end
        end
    end

    // Drain, then report.
    initial begin
        @(posedge stim_done);
        while (entropy_q.size() != 0) @(posedge clk);
        repeat (2000) @(posedge clk);
        if (errors == 0 && entropy_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog.
    initial begin
        #40000000;
        $display("== FAIL ==");
        $finish;
    end
endmodule

// ===== files.f =====
hw/rtl/bse_pkg.sv
hw/rtl/bse_in_if.sv
hw/rtl/bse_out_if.sv
hw/rtl/bse_hist.sv
hw/rtl/bse_log2.sv
hw/rtl/bse_div.sv
hw/rtl/byte_shannon_entropy.sv
hw/rtl/bse_chk.sv
tb/bse_tb_if.sv
tb/tb.sv
